### sv/keyed_name_rotate_add_hash_macros.svh
// assertion macros for the keyed rotate-add hash
`ifndef KEYED_NAME_ROTATE_ADD_HASH_MACROS_SVH
`define KEYED_NAME_ROTATE_ADD_HASH_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define KNRAH_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("knrah assertion failed");
// next-cycle implication
`define KNRAH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("knrah assertion failed");
`else
`define KNRAH_ASSERT_IMP(label, clk, rst, ante, cons)
`define KNRAH_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### sv/knrah_pkg.sv
package knrah_pkg;

   // default accumulator width
   localparam int WORD_BITS_DEF = 64;

   // fixed port widths
   localparam int KEY_PORT_BITS = 64;
   localparam int API_BITS      = 64;
   localparam int CHAR_BITS     = 8;

   // case folding of module name bytes
   localparam logic [CHAR_BITS-1:0] LOWER_FROM = 8'h61;
   localparam logic [CHAR_BITS-1:0] LOWER_BY   = 8'h20;

   // key schedule status towards the hash core
   typedef struct packed {
      logic busy;
      logic load;
   } sched_status_type;

endpackage

### sv/knrah_key_sched.sv
module knrah_key_sched #(
   parameter int WORD_BITS = knrah_pkg::WORD_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [knrah_pkg::KEY_PORT_BITS-1:0]   csr_wr_data,
   output knrah_pkg::sched_status_type           status,
   output logic [WORD_BITS-1:0]                  seed,
   output logic [WORD_BITS-1:0]                  base
);
   import knrah_pkg::*;

   localparam int KEY_BYTES = WORD_BITS / 8;
   localparam int ROT_BASE  = WORD_BITS / 8;
   localparam int ROT_SEED  = ROT_BASE + 1;
   localparam int ROT_KEY   = ROT_BASE + 2;
   localparam int STEPS     = 2 * KEY_BYTES;
   localparam int CNT_W     = $clog2(STEPS);
   localparam int BYTE_W    = $clog2(KEY_BYTES);

   logic [WORD_BITS-1:0] key_ff, key_in;
   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic [WORD_BITS-1:0] seed_ff, seed_in;
   logic [WORD_BITS-1:0] base_ff, base_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;

   logic                 key_phase;
   logic [BYTE_W-1:0]    byte_idx;
   logic [7:0]           key_byte;
   logic [WORD_BITS-1:0] acc_rot;
   logic [WORD_BITS-1:0] acc_step;
   logic                 seed_last;
   logic                 sched_last;

   // step decode: seed hash first, then key hash
   assign key_phase  = (cnt_ff >= CNT_W'(KEY_BYTES));
   assign byte_idx   = key_phase ? BYTE_W'(cnt_ff - CNT_W'(KEY_BYTES)) : BYTE_W'(cnt_ff);
   assign key_byte   = key_ff[byte_idx*8 +: 8];
   assign seed_last  = (cnt_ff == CNT_W'(KEY_BYTES - 1));
   assign sched_last = (cnt_ff == CNT_W'(STEPS - 1));

   // one rotate-add per cycle
   assign acc_rot  = key_phase ? {acc_ff[ROT_KEY-1:0], acc_ff[WORD_BITS-1:ROT_KEY]}
                               : {acc_ff[ROT_SEED-1:0], acc_ff[WORD_BITS-1:ROT_SEED]};
   assign acc_step = acc_rot + WORD_BITS'(key_byte);

   // next state
   always_comb begin
      key_in  = key_ff;
      acc_in  = acc_ff;
      seed_in = seed_ff;
      base_in = base_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (csr_wr_en) begin
         key_in  = WORD_BITS'(csr_wr_data);
         acc_in  = WORD_BITS'(csr_wr_data);
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_step;
         cnt_in = cnt_ff + CNT_W'(1);
         if (seed_last) begin
            seed_in = acc_step;
         end
         if (sched_last) begin
            base_in = seed_ff + acc_step;
            cnt_in  = '0;
            busy_in = 1'b0;
         end
      end
   end

   // schedule registers, key reset to zero
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff  <= '0;
         acc_ff  <= '0;
         cnt_ff  <= '0;
         busy_ff <= 1'b1;
      end else begin
         key_ff  <= key_in;
         acc_ff  <= acc_in;
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   // hash words, loaded during the schedule
   always_ff @(posedge clock) begin
      seed_ff <= seed_in;
      base_ff <= base_in;
   end

   assign status.busy = busy_ff;
   assign status.load = busy_ff && sched_last && !csr_wr_en;
   assign seed        = seed_ff;
   assign base        = base_ff;

endmodule

### sv/knrah_hash_core.sv
module knrah_hash_core #(
   parameter int WORD_BITS = knrah_pkg::WORD_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  knrah_pkg::sched_status_type        status,
   input  logic [WORD_BITS-1:0]               seed,
   input  logic [WORD_BITS-1:0]               base,
   input  logic                               fire,
   input  logic                               mode,
   input  logic [knrah_pkg::CHAR_BITS-1:0]    char_low,
   input  logic [knrah_pkg::CHAR_BITS-1:0]    char_high,
   input  logic                               rsp_stall,
   output logic                               out_free,
   output logic                               rsp_valid,
   output logic [knrah_pkg::API_BITS-1:0]     rsp_api_hash
);
   import knrah_pkg::*;

   localparam int ROT_BASE = WORD_BITS / 8;
   localparam int ROT_MOD  = ROT_BASE + 3;
   localparam int ROT_FUNC = ROT_BASE + 4;

   logic [WORD_BITS-1:0] mod_acc_ff, mod_acc_in;
   logic [WORD_BITS-1:0] fn_acc_ff, fn_acc_in;
   logic                 in_fn_ff, in_fn_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [API_BITS-1:0]  rsp_hash_ff, rsp_hash_in;

   logic [CHAR_BITS-1:0] low_folded;
   logic [WORD_BITS-1:0] mod_rot1, mod_sum1, mod_rot2, mod_next;
   logic [WORD_BITS-1:0] fn_rot, fn_next;
   logic                 mod_done;
   logic                 emit;
   logic [WORD_BITS-1:0] final_sum;

   // module character step: fold, rotate, add, rotate, add high byte if wide
   assign low_folded = (char_low >= LOWER_FROM) ? (char_low - LOWER_BY) : char_low;
   assign mod_rot1   = {mod_acc_ff[ROT_MOD-1:0], mod_acc_ff[WORD_BITS-1:ROT_MOD]};
   assign mod_sum1   = mod_rot1 + WORD_BITS'(low_folded);
   assign mod_rot2   = {mod_sum1[ROT_MOD-1:0], mod_sum1[WORD_BITS-1:ROT_MOD]};
   assign mod_next   = mode ? (mod_rot2 + WORD_BITS'(char_high)) : mod_rot2;
   assign mod_done   = mode ? ((low_folded == '0) && (char_high == '0))
                            : (low_folded == '0);

   // function character step; on the terminator the added byte is zero
   assign fn_rot    = {fn_acc_ff[ROT_FUNC-1:0], fn_acc_ff[WORD_BITS-1:ROT_FUNC]};
   assign fn_next   = fn_rot + WORD_BITS'(char_low);
   assign emit      = fire && in_fn_ff && (char_low == '0);
   assign final_sum = base + mod_acc_ff + fn_rot;

   // result register frees when empty or taken
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // accumulator and result next state
   always_comb begin
      mod_acc_in   = mod_acc_ff;
      fn_acc_in    = fn_acc_ff;
      in_fn_in     = in_fn_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_hash_in  = rsp_hash_ff;
      if (out_free) begin
         rsp_valid_in = emit;
      end
      if (emit) begin
         rsp_hash_in = API_BITS'(final_sum);
      end
      if (status.load) begin
         mod_acc_in = seed;
         fn_acc_in  = seed;
         in_fn_in   = 1'b0;
      end else if (fire) begin
         if (!in_fn_ff) begin
            mod_acc_in = mod_next;
            in_fn_in   = mod_done;
         end else if (emit) begin
            mod_acc_in = seed;
            fn_acc_in  = seed;
            in_fn_in   = 1'b0;
         end else begin
            fn_acc_in = fn_next;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_fn_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_fn_ff     <= in_fn_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // accumulators and result payload
   always_ff @(posedge clock) begin
      mod_acc_ff  <= mod_acc_in;
      fn_acc_ff   <= fn_acc_in;
      rsp_hash_ff <= rsp_hash_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_api_hash = rsp_hash_ff;

endmodule

### sv/keyed_name_rotate_add_hash.sv
// Keyed rotate-add name hash.
// req channel: one character per beat; req_mode picks narrow or wide module
// characters, req_char_low / req_char_high carry the bytes. A module name ends
// on a zero character, then the function name follows and ends on a zero byte.
// rsp channel: one beat with rsp_api_hash per function terminator, none else.
// csr port: csr_wr_en writes csr_wr_data as the hash key; write only when idle.
// An accepted beat is registered in the input register; a function terminator
// then has its hash registered in the result register. Throughput: one
// character per cycle while req_stall is low, set by the combinational
// rotate-add step on the running accumulators. Reset and every key write start
// a schedule over each key byte twice, one rotate-add per cycle; req_stall is
// high meanwhile. Reset leaves a zero key and the module part first.
// When rsp_stall is high the result is held; the input register still takes
// one beat, and req_stall rises only once that beat cannot move on.
`include "keyed_name_rotate_add_hash_macros.svh"

module keyed_name_rotate_add_hash #(
   parameter int WORD_BITS = knrah_pkg::WORD_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_mode,
   input  logic [knrah_pkg::CHAR_BITS-1:0]    req_char_low,
   input  logic [knrah_pkg::CHAR_BITS-1:0]    req_char_high,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [knrah_pkg::API_BITS-1:0]     rsp_api_hash,
   input  logic                               csr_wr_en,
   input  logic [knrah_pkg::KEY_PORT_BITS-1:0] csr_wr_data
);
   import knrah_pkg::*;

   sched_status_type     sched_status;
   logic [WORD_BITS-1:0] seed;
   logic [WORD_BITS-1:0] base;

   logic                 in_valid_ff, in_valid_in;
   logic                 mode_ff;
   logic [CHAR_BITS-1:0] low_ff;
   logic [CHAR_BITS-1:0] high_ff;
   logic                 out_free;
   logic                 fire;
   logic                 req_accept;

   // key schedule
   knrah_key_sched #(
      .WORD_BITS (WORD_BITS)
   ) u_key_sched (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .status      (sched_status),
      .seed        (seed),
      .base        (base)
   );

   // input register handshake
   assign fire        = in_valid_ff && out_free && !sched_status.busy;
   assign req_stall   = sched_status.busy || (in_valid_ff && !fire);
   assign req_accept  = req_valid && !req_stall;
   assign in_valid_in = req_accept || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // input beat payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         mode_ff <= req_mode;
         low_ff  <= req_char_low;
         high_ff <= req_char_high;
      end
   end

   // accumulators and result register
   knrah_hash_core #(
      .WORD_BITS (WORD_BITS)
   ) u_hash_core (
      .clock        (clock),
      .reset        (reset),
      .status       (sched_status),
      .seed         (seed),
      .base         (base),
      .fire         (fire),
      .mode         (mode_ff),
      .char_low     (low_ff),
      .char_high    (high_ff),
      .rsp_stall    (rsp_stall),
      .out_free     (out_free),
      .rsp_valid    (rsp_valid),
      .rsp_api_hash (rsp_api_hash)
   );

   // checks
   `KNRAH_ASSERT_IMP(a_sched_blocks_req, clock, reset, sched_status.busy, req_stall)
   `KNRAH_ASSERT_NEXT(a_accept_fills_input, clock, reset, req_accept, in_valid_ff)
   `KNRAH_ASSERT_NEXT(a_load_ends_sched, clock, reset, sched_status.load, !sched_status.busy)

endmodule

### bench/knrah_checker.sv
module knrah_checker #(
   parameter int WORD_BITS = knrah_pkg::WORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic                                req_mode,
   input  logic [knrah_pkg::CHAR_BITS-1:0]     req_char_low,
   input  logic [knrah_pkg::CHAR_BITS-1:0]     req_char_high,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [knrah_pkg::API_BITS-1:0]      rsp_api_hash,
   input  logic                                csr_wr_en,
   input  logic [knrah_pkg::KEY_PORT_BITS-1:0] csr_wr_data,
   input  logic                                drain_done,
   output int                                  outstanding,
   output int                                  mismatches
);

   // rotate amounts per stage of the hash
   localparam int ROT_BASE  = WORD_BITS / 8;
   localparam int KEY_BYTES = WORD_BITS / 8;
   localparam int ROT_SEED  = ROT_BASE + 1;
   localparam int ROT_KEY   = ROT_BASE + 2;
   localparam int ROT_MOD   = ROT_BASE + 3;
   localparam int ROT_FUNC  = ROT_BASE + 4;

   typedef logic [WORD_BITS-1:0]            word_type;
   typedef logic [knrah_pkg::CHAR_BITS-1:0] char_type;

   word_type seed_word;
   word_type key_word;
   word_type module_word;
   word_type function_word;
   bit       in_function;
   bit       leftovers_reported;

   logic [knrah_pkg::API_BITS-1:0] expected_hashes[$];
   logic [knrah_pkg::API_BITS-1:0] head_hash;

   initial begin
      outstanding        = 0;
      mismatches         = 0;
      leftovers_reported = 1'b0;
   end

   task automatic report_mismatch(input string text);
      $display("[%0t] hash check: %s", $time, text);
      mismatches++;
   endtask

   function automatic word_type ror(input word_type value, input int amount);
      return (value >> amount) | (value << (WORD_BITS - amount));
   endfunction

   // fold the key bytes, least significant first, into a running word
   function automatic word_type mix_key_bytes(input word_type start, input word_type hash_key,
                                              input int amount);
      word_type acc;
      acc = start;
      for (int i = 0; i < KEY_BYTES; i++)
         acc = ror(acc, amount) + hash_key[8*i +: 8];
      return acc;
   endfunction

   // new key: seed and key words, accumulators back to the seed, module part first
   task automatic rekey(input logic [knrah_pkg::KEY_PORT_BITS-1:0] value);
      word_type hash_key;
      hash_key      = value[WORD_BITS-1:0];
      seed_word     = mix_key_bytes(hash_key, hash_key, ROT_SEED);
      key_word      = mix_key_bytes(seed_word, hash_key, ROT_KEY);
      module_word   = seed_word;
      function_word = seed_word;
      in_function   = 1'b0;
   endtask

   // one character beat into the running hashes
   task automatic absorb_char(input logic wide, input char_type low, input char_type high);
      char_type folded;
      bit       name_end;
      word_type total;
      if (!in_function) begin
         folded      = (low >= knrah_pkg::LOWER_FROM) ? low - knrah_pkg::LOWER_BY : low;
         module_word = ror(module_word, ROT_MOD) + folded;
         module_word = ror(module_word, ROT_MOD);
         if (wide) begin
            // high byte is added as it is, no case folding
            module_word = module_word + high;
            name_end    = (folded == '0) && (high == '0);
         end else begin
            name_end = (folded == '0);
         end
         if (name_end)
            in_function = 1'b1;
      end else begin
         function_word = ror(function_word, ROT_FUNC) + low;
         // function terminator gives the hash and starts a new module name
         if (low == '0) begin
            total = seed_word + key_word + module_word + function_word;
            expected_hashes.push_back(total);
            module_word   = seed_word;
            function_word = seed_word;
            in_function   = 1'b0;
         end
      end
   endtask

   // watch the channels at every edge
   always @(posedge clock) begin
      if (reset) begin
         expected_hashes.delete();
         rekey('0);
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_hashes.size() == 0) begin
               report_mismatch($sformatf("result beat %h with nothing expected",
                                         rsp_api_hash));
            end else begin
               head_hash = expected_hashes.pop_front();
               if (rsp_api_hash !== head_hash)
                  report_mismatch($sformatf("api_hash %h, expected %h",
                                            rsp_api_hash, head_hash));
            end
         end
         if (csr_wr_en)
            rekey(csr_wr_data);
         if (req_valid && !req_stall)
            absorb_char(req_mode, req_char_low, req_char_high);
      end
      // anything still queued at the end never came out
      if (drain_done && !leftovers_reported) begin
         leftovers_reported = 1'b1;
         foreach (expected_hashes[i])
            report_mismatch($sformatf("expected %h never arrived", expected_hashes[i]));
      end
      outstanding <= expected_hashes.size();
   end

endmodule

### bench/testbench.sv
module testbench;

   localparam logic MODE_NARROW     = 1'b0;
   localparam logic MODE_WIDE       = 1'b1;
   localparam int   PHASES          = 8;
   localparam int   CHARS_PER_PHASE = 110;
   localparam int   LATENCY_WAIT    = 6;
   localparam int   HOLD_CYCLES     = 120;
   localparam int   CYCLE_LIMIT     = 400000;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_stall;
   logic                                req_mode;
   logic [knrah_pkg::CHAR_BITS-1:0]     req_char_low;
   logic [knrah_pkg::CHAR_BITS-1:0]     req_char_high;
   logic                                rsp_valid;
   logic                                rsp_stall;
   logic [knrah_pkg::API_BITS-1:0]      rsp_api_hash;
   logic                                csr_wr_en;
   logic [knrah_pkg::KEY_PORT_BITS-1:0] csr_wr_data;
   logic                                drain_done;
   int                                  outstanding;
   int                                  mismatches;

   int chars_sent;
   int cycle_count;
   bit sender_calm;
   bit receiver_calm;
   bit hold_request;

   keyed_name_rotate_add_hash u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_char_low  (req_char_low),
      .req_char_high (req_char_high),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_api_hash  (rsp_api_hash),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   knrah_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_char_low  (req_char_low),
      .req_char_high (req_char_high),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_api_hash  (rsp_api_hash),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .drain_done    (drain_done),
      .outstanding   (outstanding),
      .mismatches    (mismatches)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // result side: a random stall per result beat, or one long hold-off on request
   initial begin : result_side
      int stall_left;
      bit hard_hold;
      rsp_stall <= 1'b0;
      stall_left = 0;
      hard_hold  = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = HOLD_CYCLES;
            hard_hold    = 1'b1;
         end else if (rsp_valid && !rsp_stall) begin
            stall_left = receiver_calm ? 0 : $urandom_range(0, 9);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            // a normal stall only counts while a result waits
            if (hard_hold || rsp_valid)
               stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            hard_hold = 1'b0;
         end
      end
   end

   function automatic logic [7:0] pick_byte();
      if ($urandom_range(0, 4) < 3)
         return 8'($urandom_range(8'h20, 8'h7E));
      return 8'($urandom_range(1, 255));
   endfunction

   // offer one character beat after a random gap and wait for it to be taken
   task automatic put_char(input logic mode, input logic [7:0] low, input logic [7:0] high);
      int gap;
      gap = sender_calm ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= mode;
      req_char_low  <= low;
      req_char_high <= high;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      chars_sent++;
   endtask

   // stop offering until every expected hash is back, then let the pipe empty
   task automatic settle(input int extra);
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_key(input logic [knrah_pkg::KEY_PORT_BITS-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // module name: mostly one mode, now and then a character in the other
   task automatic send_module_part(input int len, input bit terminate);
      logic       name_mode;
      logic       mode;
      logic [7:0] low;
      logic [7:0] high;
      name_mode = 1'($urandom_range(0, 1));
      for (int i = 0; i < len; i++) begin
         mode = ($urandom_range(0, 9) == 0) ? ~name_mode : name_mode;
         if (mode == MODE_WIDE) begin
            low  = ($urandom_range(0, 3) == 0) ? 8'h00 : pick_byte();
            high = (low == 8'h00) ? 8'($urandom_range(1, 255)) : 8'($urandom_range(0, 255));
         end else begin
            low  = pick_byte();
            high = 8'($urandom_range(0, 255));
         end
         put_char(mode, low, high);
      end
      if (terminate) begin
         if ($urandom_range(0, 1))
            put_char(MODE_WIDE, 8'h00, 8'h00);
         else
            put_char(MODE_NARROW, 8'h00, 8'($urandom_range(0, 255)));
      end
   endtask

   // function name: mode and high byte play no part here
   task automatic send_function_part(input int len, input bit terminate);
      for (int i = 0; i < len; i++)
         put_char(1'($urandom_range(0, 1)), pick_byte(), 8'($urandom_range(0, 255)));
      if (terminate)
         put_char(1'($urandom_range(0, 1)), 8'h00, 8'($urandom_range(0, 255)));
   endtask

   function automatic int name_length();
      if ($urandom_range(0, 19) == 0)
         return $urandom_range(11, 40);
      return $urandom_range(0, 10);
   endfunction

   // one random stretch: a whole name, noise, or a pause until drained
   task automatic send_name();
      int pick;
      int count;
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
         send_module_part(name_length(), 1'b1);
         send_function_part(name_length(), 1'b1);
      end else if (pick < 92) begin
         count = $urandom_range(1, 8);
         repeat (count)
            put_char(1'($urandom_range(0, 1)),
                     ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255)),
                     ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
      end else begin
         settle($urandom_range(0, 3));
      end
   endtask

   function automatic logic [knrah_pkg::KEY_PORT_BITS-1:0] phase_key(input int phase);
      case (phase)
         0:       return '1;
         1:       return 64'h8000_0000_0000_0001;
         3:       return '0;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   initial begin : stimulus
      int target;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_mode      <= MODE_NARROW;
      req_char_low  <= '0;
      req_char_high <= '0;
      csr_wr_en     <= 1'b0;
      csr_wr_data   <= '0;
      drain_done    <= 1'b0;
      chars_sent    = 0;
      sender_calm   = 1'b0;
      receiver_calm = 1'b0;
      hold_request  = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // narrow name: folding from 0x61 up, 0xff included, 0x60 and 'A' untouched,
      // high byte ignored on the terminator, mode ignored in the function part
      put_char(MODE_NARROW, 8'h61, 8'h00);
      put_char(MODE_NARROW, 8'hFF, 8'hFF);
      put_char(MODE_NARROW, 8'h60, 8'h5A);
      put_char(MODE_NARROW, 8'h41, 8'h00);
      put_char(MODE_NARROW, 8'h00, 8'hFF);
      put_char(MODE_WIDE,   8'hFF, 8'h00);
      put_char(MODE_NARROW, 8'h01, 8'h00);
      put_char(MODE_NARROW, 8'h00, 8'h00);
      // wide name: high byte not folded, zero low byte alone does not end it,
      // a narrow character in the middle
      put_char(MODE_WIDE,   8'h61, 8'hFF);
      put_char(MODE_WIDE,   8'h00, 8'h80);
      put_char(MODE_WIDE,   8'hFF, 8'h00);
      put_char(MODE_NARROW, 8'h7A, 8'h33);
      put_char(MODE_WIDE,   8'h00, 8'h00);
      put_char(MODE_NARROW, 8'h80, 8'h00);
      put_char(MODE_WIDE,   8'h00, 8'hFF);
      // empty names in both modes
      put_char(MODE_NARROW, 8'h00, 8'h00);
      put_char(MODE_NARROW, 8'h00, 8'h00);
      put_char(MODE_WIDE,   8'h00, 8'h00);
      put_char(MODE_WIDE,   8'h00, 8'h00);

      // one key per phase; phase 2 runs without idling, phase 3 holds results off
      for (int phase = 0; phase < PHASES; phase++) begin
         settle(LATENCY_WAIT);
         write_key(phase_key(phase));
         sender_calm   = (phase == 2) || (phase == 3);
         receiver_calm = (phase == 2);
         if (phase == 3)
            hold_request = 1'b1;
         target = chars_sent + CHARS_PER_PHASE;
         while (chars_sent < target)
            send_name();
         // at random, leave a name unfinished so the next key write cuts it off
         if ($urandom_range(0, 1)) begin
            if ($urandom_range(0, 1)) begin
               send_module_part($urandom_range(1, 5), 1'b0);
            end else begin
               send_module_part($urandom_range(0, 5), 1'b1);
               send_function_part($urandom_range(1, 5), 1'b0);
            end
         end
      end

      settle(LATENCY_WAIT);
      drain_done <= 1'b1;
      repeat (2) @(posedge clock);
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
